[hdl/truss_element_stiffness_force_assert.svh]
// Assertion macros shared by the truss element RTL.
`ifndef TRUSS_ELEMENT_STIFFNESS_FORCE_ASSERT_SVH
`define TRUSS_ELEMENT_STIFFNESS_FORCE_ASSERT_SVH

// same-cycle implication
`define TESF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TESF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tesf_pkg.sv]
// Shared types, constants and helpers for the truss element block.
package tesf_pkg;

  localparam int WORD_W     = 32;
  localparam int IN_DATA_W  = 8 * WORD_W;
  localparam int IN_USER_W  = 2;
  localparam int RES_W      = 64;
  localparam int NUM_RES    = 12;
  localparam int OUT_DATA_W = NUM_RES * RES_W;
  localparam int ACC_W      = 160;
  localparam int NUM_W      = 80;
  localparam int REM0_W     = 34;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [63:0] CAP63 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]        op;
    logic [NUM_W-1:0]  a;
    logic [63:0]       b;
    logic [REM0_W-1:0] rem0;
    logic [6:0]        steps;
  } tesf_cmd_t;

  // magnitude clamped to 2^63
  function automatic logic [63:0] clamp_mag(input logic [ACC_W-1:0] v);
    logic over;
    over = (|v[ACC_W-1:64]) || (v[63] && (|v[62:0]));
    return over ? CAP63 : v[63:0];
  endfunction

  // sign and magnitude to saturated two's complement
  function automatic logic [63:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [63:0] r;
    if (neg) r = mag[63] ? CAP63 : (64'd0 - mag);
    else     r = mag[63] ? MAX63 : mag;
    return r;
  endfunction

endpackage

[hdl/tesf_alu.sv]
// Shared multi-cycle arithmetic unit: limb multiply, restoring divide, square root.
module tesf_alu (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  tesf_pkg::tesf_cmd_t   cmd,
  output logic                  done,
  output logic [159:0]          res
);
  import tesf_pkg::*;

  localparam logic [6:0] MulLimbs = 7'd6;

  logic [1:0]        op_r;
  logic [95:0]       a_r;
  logic [63:0]       b_r;
  logic [6:0]        cnt_r;
  logic              busy_r, done_r, pv_r;
  logic [ACC_W-1:0]  acc_r;
  logic [63:0]       prod_r;
  logic [1:0]        sh_r;
  logic [NUM_W-1:0]  num_r;
  logic [34:0]       rem_r;
  logic [33:0]       root_r;

  logic [31:0]       la, lb;
  logic [ACC_W-1:0]  psh;
  logic [34:0]       t35;
  logic              dge;
  logic [36:0]       t37, trial;
  logic              sge;

  always_comb begin
    la  = a_r[32*cnt_r[2:1] +: 32];
    lb  = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    case (sh_r)
      2'd0:    psh = {96'd0, prod_r};
      2'd1:    psh = {64'd0, prod_r, 32'd0};
      2'd2:    psh = {32'd0, prod_r, 64'd0};
      default: psh = {prod_r, 96'd0};
    endcase
    t35   = {rem_r[33:0], num_r[NUM_W-1]};
    dge   = t35 >= {1'b0, b_r[33:0]};
    t37   = {rem_r, num_r[NUM_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    sge   = t37 >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        op_r   <= cmd.op;
        a_r    <= {16'd0, cmd.a};
        b_r    <= cmd.b;
        cnt_r  <= (cmd.op == OP_MUL) ? 7'd0 : cmd.steps;
        num_r  <= cmd.a;
        rem_r  <= {1'b0, cmd.rem0};
        root_r <= '0;
        acc_r  <= '0;
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
      end else if (busy_r) begin
        unique case (op_r)
          OP_MUL: begin
            pv_r <= (cnt_r < MulLimbs);
            if (cnt_r < MulLimbs) begin
              prod_r <= la * lb;
              sh_r   <= cnt_r[2:1] + {1'b0, cnt_r[0]};
            end
            if (pv_r) acc_r <= acc_r + psh;
            if (cnt_r == MulLimbs) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
            cnt_r <= cnt_r + 7'd1;
          end
          OP_DIV: begin
            rem_r <= dge ? (t35 - {1'b0, b_r[33:0]}) : t35;
            num_r <= {num_r[NUM_W-2:0], dge};
            cnt_r <= cnt_r - 7'd1;
            if (cnt_r == 7'd1) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          OP_SQRT: begin
            rem_r  <= sge ? 35'(t37 - trial) : 35'(t37);
            root_r <= {root_r[32:0], sge};
            num_r  <= {num_r[NUM_W-3:0], 2'b00};
            cnt_r  <= cnt_r - 7'd1;
            if (cnt_r == 7'd1) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: busy_r <= 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    case (op_r)
      OP_MUL:  res = acc_r;
      OP_DIV:  res = {80'd0, num_r};
      OP_SQRT: res = {126'd0, root_r};
      default: res = '0;
    endcase
  end

  assign done = done_r;

endmodule

[hdl/truss_element_stiffness_force.sv]
// Top level: 3D truss element stiffness terms and axial results.
//
//  channel  | dir | data                         | side band
//  in_      | in  | 8 x 32-bit node/element data | tuser: node select, forces
//  out_     | out | 12 x 64-bit Q32.32 results   | none
//
// An element takes longer with forces than with stiffness only; the time is set by
// the shared unit, whose divisions, square root and six-limb 32x32 multiplies
// run one after another.
// A node-zero beat is stored when it is accepted. Reset needs no clearing pass.
// The input is not ready from the node-one beat until the result beat leaves.
`include "truss_element_stiffness_force_assert.svh"
module truss_element_stiffness_force (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pos_x, pos_y, pos_z, disp_x, disp_y, disp_z, cross_area, elastic_modulus
  input  logic [tesf_pkg::IN_DATA_W-1:0]   in_tdata,
  // second_node, with_forces
  input  logic [tesf_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // k_xx, k_xy, k_xz, k_yy, k_yz, k_zz, node_force_x, node_force_y,
  // node_force_z, axial_force, axial_stress, axial_strain
  output logic [tesf_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import tesf_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_SQRT = 4'd2;
  localparam logic [3:0] ST_AM   = 4'd3;
  localparam logic [3:0] ST_NAS0 = 4'd4;
  localparam logic [3:0] ST_NAS  = 4'd5;
  localparam logic [3:0] ST_KP   = 4'd6;
  localparam logic [3:0] ST_KN   = 4'd7;
  localparam logic [3:0] ST_EL   = 4'd8;
  localparam logic [3:0] ST_F    = 4'd9;
  localparam logic [3:0] ST_NF   = 4'd10;
  localparam logic [3:0] ST_ST   = 4'd11;
  localparam logic [3:0] ST_SN   = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  localparam logic [1:0] KI [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] KJ [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  logic [3:0]         state_r;
  logic [2:0]         idx_r;
  logic               wait_r;
  logic               first_seen_r;
  logic [WORD_W-1:0]  first_pos_r  [3];
  logic [WORD_W-1:0]  first_disp_r [3];
  logic [32:0]        dmag_r [3];
  logic               dneg_r [3];
  logic [32:0]        umag_r [3];
  logic               uneg_r [3];
  logic [WORD_W-1:0]  area_r, mod_r;
  logic               forces_r;
  logic [65:0]        sq_r;
  logic [33:0]        len_r;
  logic [30:0]        amag_r [3];
  logic [63:0]        am_r;
  logic [NUM_W-1:0]   nas_r;
  logic [61:0]        p_r;
  logic [63:0]        eacc_r;
  logic [63:0]        fmag_r, smag_r;
  logic [63:0]        res_r [NUM_RES];

  logic               in_acc;
  logic [32:0]        dd [3];
  logic [32:0]        du [3];
  logic               eneg;
  logic [63:0]        emag;
  logic               alu_start, alu_done;
  logic [ACC_W-1:0]   alu_res;
  tesf_cmd_t          cmd;
  logic [63:0]        term;
  logic [63:0]        q_clamp;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign in_acc     = in_tvalid && in_tready;
  assign alu_start  = (state_r != ST_IDLE) && (state_r != ST_OUT) && !wait_r;
  assign eneg       = eacc_r[63];
  assign emag       = eneg ? (64'd0 - eacc_r) : eacc_r;
  assign term       = alu_res[65:2];
  assign q_clamp    = clamp_mag({80'd0, alu_res[NUM_W-1:0]});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = {in_tdata[32*i+31], in_tdata[32*i +: 32]}
            - {first_pos_r[i][WORD_W-1], first_pos_r[i]};
      du[i] = {in_tdata[96+32*i+31], in_tdata[96+32*i +: 32]}
            - {first_disp_r[i][WORD_W-1], first_disp_r[i]};
    end
    for (int i = 0; i < NUM_RES; i++) out_tdata[64*i +: 64] = res_r[i];
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_SQ: begin
        cmd.op = OP_MUL;
        cmd.a  = 80'(dmag_r[idx_r[1:0]]);
        cmd.b  = 64'(dmag_r[idx_r[1:0]]);
      end
      ST_SQRT: begin
        cmd.op    = OP_SQRT;
        cmd.a     = {2'b00, sq_r, 12'd0};
        cmd.steps = 7'd34;
      end
      ST_AM: begin
        // quotient fits 31 bits, so start with the upper numerator in place
        cmd.op    = OP_DIV;
        cmd.rem0  = 34'(dmag_r[idx_r[1:0]][32:1]);
        cmd.a     = {dmag_r[idx_r[1:0]][0], 79'd0};
        cmd.b     = 64'(len_r);
        cmd.steps = 7'd31;
      end
      ST_NAS0: begin
        cmd.op = OP_MUL;
        cmd.a  = 80'(area_r);
        cmd.b  = 64'(mod_r);
      end
      ST_NAS: begin
        cmd.op    = OP_DIV;
        cmd.a     = {am_r, 16'd0};
        cmd.b     = 64'(len_r);
        cmd.steps = 7'd80;
      end
      ST_KP: begin
        cmd.op = OP_MUL;
        cmd.a  = 80'(amag_r[KI[idx_r]]);
        cmd.b  = 64'(amag_r[KJ[idx_r]]);
      end
      ST_KN: begin
        cmd.op = OP_MUL;
        cmd.a  = nas_r;
        cmd.b  = 64'(p_r);
      end
      ST_EL: begin
        cmd.op = OP_MUL;
        cmd.a  = 80'(amag_r[idx_r[1:0]]);
        cmd.b  = 64'(umag_r[idx_r[1:0]]);
      end
      ST_F: begin
        cmd.op = OP_MUL;
        cmd.a  = nas_r;
        cmd.b  = emag;
      end
      ST_NF: begin
        cmd.op = OP_MUL;
        cmd.a  = 80'(fmag_r);
        cmd.b  = 64'(amag_r[idx_r[1:0]]);
      end
      ST_ST: begin
        cmd.op    = OP_DIV;
        cmd.a     = {fmag_r, 16'd0};
        cmd.b     = 64'(area_r);
        cmd.steps = 7'd80;
      end
      ST_SN: begin
        cmd.op    = OP_DIV;
        cmd.a     = {smag_r, 16'd0};
        cmd.b     = 64'(mod_r);
        cmd.steps = 7'd80;
      end
      default: cmd = '0;
    endcase
  end

  tesf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (alu_start),
    .cmd   (cmd),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      wait_r       <= 1'b0;
      first_seen_r <= 1'b0;
    end else begin
      if (alu_start) wait_r <= 1'b1;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && !in_tuser[0]) begin
            for (int i = 0; i < 3; i++) begin
              first_pos_r[i]  <= in_tdata[32*i +: 32];
              first_disp_r[i] <= in_tdata[96+32*i +: 32];
            end
            first_seen_r <= 1'b1;
          end else if (in_acc && first_seen_r) begin
            for (int i = 0; i < 3; i++) begin
              dneg_r[i] <= dd[i][32];
              dmag_r[i] <= dd[i][32] ? (33'd0 - dd[i]) : dd[i];
              uneg_r[i] <= du[i][32];
              umag_r[i] <= du[i][32] ? (33'd0 - du[i]) : du[i];
            end
            for (int i = 0; i < NUM_RES; i++) res_r[i] <= '0;
            area_r       <= in_tdata[192 +: 32];
            mod_r        <= in_tdata[224 +: 32];
            forces_r     <= in_tuser[1];
            sq_r         <= '0;
            eacc_r       <= '0;
            idx_r        <= '0;
            first_seen_r <= 1'b0;
            state_r      <= ST_SQ;
          end
        end
        ST_OUT: begin
          if (out_tready) state_r <= ST_IDLE;
        end
        default: begin
          if (alu_done) begin
            wait_r <= 1'b0;
            unique case (state_r)
              ST_SQ: begin
                sq_r  <= sq_r + alu_res[65:0];
                idx_r <= (idx_r == 3'd2) ? 3'd0 : idx_r + 3'd1;
                if (idx_r == 3'd2) state_r <= ST_SQRT;
              end
              ST_SQRT: begin
                len_r <= alu_res[33:0];
                if (alu_res[33:0] == '0 || area_r == '0 || mod_r == '0)
                  state_r <= ST_OUT;
                else
                  state_r <= ST_AM;
              end
              ST_AM: begin
                amag_r[idx_r[1:0]] <= (alu_res[30:0] > 31'h4000_0000) ?
                                      31'h4000_0000 : alu_res[30:0];
                idx_r <= (idx_r == 3'd2) ? 3'd0 : idx_r + 3'd1;
                if (idx_r == 3'd2) state_r <= ST_NAS0;
              end
              ST_NAS0: begin
                am_r    <= alu_res[63:0];
                state_r <= ST_NAS;
              end
              ST_NAS: begin
                nas_r   <= alu_res[NUM_W-1:0];
                state_r <= ST_KP;
              end
              ST_KP: begin
                p_r     <= alu_res[61:0];
                state_r <= ST_KN;
              end
              ST_KN: begin
                res_r[idx_r] <= sat_mag(dneg_r[KI[idx_r]] != dneg_r[KJ[idx_r]],
                                        clamp_mag(alu_res >> 60));
                if (idx_r == 3'd5) begin
                  idx_r   <= '0;
                  state_r <= forces_r ? ST_EL : ST_OUT;
                end else begin
                  idx_r   <= idx_r + 3'd1;
                  state_r <= ST_KP;
                end
              end
              ST_EL: begin
                eacc_r <= (uneg_r[idx_r[1:0]] != dneg_r[idx_r[1:0]]) ?
                          eacc_r - term : eacc_r + term;
                idx_r  <= (idx_r == 3'd2) ? 3'd0 : idx_r + 3'd1;
                if (idx_r == 3'd2) state_r <= ST_F;
              end
              ST_F: begin
                fmag_r   <= clamp_mag(alu_res >> 44);
                res_r[9] <= sat_mag(eneg, clamp_mag(alu_res >> 44));
                state_r  <= ST_NF;
              end
              ST_NF: begin
                res_r[6 + 32'(idx_r)] <= sat_mag(dneg_r[idx_r[1:0]] == eneg,
                                                 clamp_mag(alu_res >> 30));
                idx_r <= (idx_r == 3'd2) ? 3'd0 : idx_r + 3'd1;
                if (idx_r == 3'd2) state_r <= ST_ST;
              end
              ST_ST: begin
                smag_r    <= q_clamp;
                res_r[10] <= sat_mag(eneg, q_clamp);
                state_r   <= ST_SN;
              end
              ST_SN: begin
                res_r[11] <= sat_mag(eneg, q_clamp);
                state_r   <= ST_OUT;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  `TESF_ASSERT_NOW(a_one_item, out_tvalid, !in_tready, "input taken while result pending")
  `TESF_ASSERT_NOW(a_done_waited, alu_done, wait_r, "unit finished with no command issued")
  `TESF_ASSERT_NOW(a_len_nonzero, state_r == ST_AM && alu_done, len_r != '0,
                   "cosine divide with zero length")
  `TESF_ASSERT_NEXT(a_pair_start, in_acc && in_tuser[0] && first_seen_r,
                    state_r == ST_SQ && !first_seen_r, "element pair did not start")

endmodule

[tb/sv/tb_truss_element_stiffness_force.sv]
// Testbench for the truss element stiffness and axial force block.
`timescale 1ns / 100ps
module tb_truss_element_stiffness_force;
  import tesf_pkg::*;

  typedef logic [NUM_RES-1:0][RES_W-1:0] elem_res_t;
  typedef struct packed {
    logic [IN_USER_W-1:0] user;
    logic [IN_DATA_W-1:0] data;
  } node_beat_t;

  localparam logic [127:0] CAP = 128'h1 << 63;
  localparam logic [63:0]  ONE_Q30 = 64'h1 << 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  truss_element_stiffness_force uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  node_beat_t pending_nodes[$];
  elem_res_t  expected_elems[$];
  int         mismatch_cnt = 0;
  logic       beat_taken = 1'b0;
  logic       drv_busy = 1'b0;

  // held node zero
  logic signed [63:0] held_pos[3];
  logic signed [63:0] held_disp[3];
  logic               held_valid = 1'b0;

  // min(x*p >> s, 2^63)
  function automatic logic [63:0] scaled_mag(input logic [127:0] x, input logic [63:0] p,
                                             input int s);
    logic [255:0] prod;
    prod = ({128'd0, x} * {192'd0, p}) >> s;
    return (prod > {128'd0, CAP}) ? CAP[63:0] : prod[63:0];
  endfunction

  function automatic logic [63:0] sat_val(input logic neg, input logic [63:0] mag);
    if (neg) return mag[63] ? 64'h8000_0000_0000_0000 : 64'd0 - mag;
    return mag[63] ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
  endfunction

  function automatic logic [63:0] div_clamped(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, num} << 16) / {64'd0, den};
    return (q > CAP) ? CAP[63:0] : q[63:0];
  endfunction

  // returns 1 when the beat completes an element
  function automatic bit truss_predict(input node_beat_t b, output elem_res_t r);
    logic signed [63:0] pos[3], disp[3], dd, du, acc, term;
    logic [63:0] dmag[3], amag[3], umag, area, modulus, len, emag, fmag, smag, m;
    logic dneg[3], eneg, uneg;
    logic [127:0] sq, cand, nas;
    int ki[6], kj[6];
    ki = '{0, 0, 0, 1, 1, 2};
    kj = '{0, 1, 2, 1, 2, 2};
    r = '0;
    for (int i = 0; i < 3; i++) begin
      pos[i]  = {{32{b.data[32*i+31]}}, b.data[32*i +: 32]};
      disp[i] = {{32{b.data[32*(i+3)+31]}}, b.data[32*(i+3) +: 32]};
    end
    if (!b.user[0]) begin
      held_pos = pos;
      held_disp = disp;
      held_valid = 1'b1;
      return 0;
    end
    if (!held_valid) return 0;
    held_valid = 1'b0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      dd = pos[i] - held_pos[i];
      dneg[i] = dd < 0;
      dmag[i] = dneg[i] ? -dd : dd;
      sq += {64'd0, dmag[i]} * {64'd0, dmag[i]};
    end
    len = 0;
    for (int k = 35; k >= 0; k--) begin
      cand = {64'd0, len | (64'd1 << k)};
      if (cand * cand <= sq) len = cand[63:0];
    end
    area = b.data[32*6 +: 32];
    modulus = b.data[32*7 +: 32];
    if (len == 0 || area == 0 || modulus == 0) return 1;
    for (int i = 0; i < 3; i++) begin
      amag[i] = (dmag[i] << 30) / len;
      if (amag[i] > ONE_Q30) amag[i] = ONE_Q30;
    end
    nas = ({64'd0, area * modulus} << 16) / {64'd0, len};
    for (int i = 0; i < 6; i++) begin
      m = scaled_mag(nas, amag[ki[i]] * amag[kj[i]], 60);
      r[i] = sat_val(dneg[ki[i]] != dneg[kj[i]], m);
    end
    if (b.user[1]) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        du = disp[i] - held_disp[i];
        uneg = du < 0;
        umag = uneg ? -du : du;
        term = (amag[i] * umag) >> 2;
        acc += (uneg != dneg[i]) ? -term : term;
      end
      eneg = acc < 0;
      emag = eneg ? 64'd0 - acc : acc;
      fmag = scaled_mag(nas, emag, 44);
      for (int i = 0; i < 3; i++)
        r[6+i] = sat_val(dneg[i] == eneg, scaled_mag({64'd0, fmag}, amag[i], 30));
      r[9] = sat_val(eneg, fmag);
      smag = div_clamped(fmag, area);
      r[10] = sat_val(eneg, smag);
      r[11] = sat_val(eneg, div_clamped(smag, modulus));
    end
    return 1;
  endfunction

  function automatic node_beat_t mk_node(input bit second, input bit forces,
      input logic [31:0] px, py, pz, ux, uy, uz, area, modulus);
    node_beat_t b;
    b.user = {forces, second};
    b.data = {modulus, area, uz, uy, ux, pz, py, px};
    return b;
  endfunction

  // mostly moderate values, some full-range
  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] rnd_prop();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3);
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  // input acceptance and prediction
  always @(posedge clk) begin
    elem_res_t r;
    beat_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      if (truss_predict({in_tuser, in_tdata}, r)) expected_elems.push_back(r);
    end
  end

  // driver: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    node_beat_t b;
    if (rst_n) begin
      if (beat_taken) drv_busy = 1'b0;
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_nodes.size() > 0) begin
          b = pending_nodes.pop_front();
          in_tdata <= b.data;
          in_tuser <= b.user;
          in_tvalid <= 1'b1;
          drv_busy = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  int stall_left = 0;
  int run_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = $urandom_range(0, 30);
          stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
        end
      end
    end
  end

  // result check
  always @(posedge clk) begin
    elem_res_t want;
    elem_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_elems.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected result beat: %h", got);
      end else begin
        want = expected_elems.pop_front();
        for (int i = 0; i < NUM_RES; i++)
          if (got[i] !== want[i]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("Result field %0d mismatch: expected %h actual %h", i, want[i], got[i]);
          end
      end
    end
  end

  initial begin
    logic [31:0] px, py, pz;
    // directed
    pending_nodes.push_back(mk_node(1, 1, 32'h10000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000));
    pending_nodes.push_back(mk_node(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_nodes.push_back(mk_node(0, 0, 32'h5000, 0, 0, 0, 0, 0, 0, 0));
    pending_nodes.push_back(mk_node(1, 0, 32'h30000, 32'h40000, 0, 0, 0, 0,
                                    32'h20000, 32'h30000));
    pending_nodes.push_back(mk_node(1, 1, 32'h30000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000));
    pending_nodes.push_back(mk_node(0, 1, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0, 0));
    pending_nodes.push_back(mk_node(1, 1, 32'h10000, 32'h10000, 32'h10000, 32'h100, 0, 0,
                                    32'h10000, 32'h10000));
    pending_nodes.push_back(mk_node(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_nodes.push_back(mk_node(1, 1, 32'h10000, 0, 0, 32'h100, 0, 0, 0, 32'h10000));
    pending_nodes.push_back(mk_node(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_nodes.push_back(mk_node(1, 1, 0, 32'h10000, 0, 0, 32'h100, 0, 32'h10000, 0));
    pending_nodes.push_back(mk_node(0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    pending_nodes.push_back(mk_node(1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_nodes.push_back(mk_node(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_nodes.push_back(mk_node(1, 1, 1, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, 1));
    pending_nodes.push_back(mk_node(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_nodes.push_back(mk_node(1, 1, 32'hFFFF_0000, 32'h2_0000, 32'hFFFD_0000,
                                    32'hFFFF_FF00, 32'h200, 32'h80, 32'h8000, 32'h4_0000));
    pending_nodes.push_back(mk_node(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_nodes.push_back(mk_node(1, 1, 32'h10, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0,
                                    32'h1, 32'hFFFF_FFFF));
    // random: mostly complete elements, some noise
    for (int n = 0; n < 270; n++) begin
      px = rnd_word(); py = rnd_word(); pz = rnd_word();
      case ($urandom_range(0, 9))
        0: pending_nodes.push_back(mk_node(1, $urandom_range(0, 1), px, py, pz, rnd_word(),
                                           rnd_word(), rnd_word(), rnd_prop(), rnd_prop()));
        1: pending_nodes.push_back(mk_node(0, 0, px, py, pz, rnd_word(), rnd_word(),
                                           rnd_word(), $urandom(), $urandom()));
        default: begin
          pending_nodes.push_back(mk_node(0, $urandom_range(0, 1), px, py, pz, rnd_word(),
                                          rnd_word(), rnd_word(), $urandom(), $urandom()));
          if ($urandom_range(0, 7) == 0) begin
            px = rnd_word(); py = rnd_word(); pz = rnd_word();
          end else begin
            px = px + rnd_word(); py = py + rnd_word(); pz = pz + rnd_word();
          end
          pending_nodes.push_back(mk_node(1, $urandom_range(0, 3) != 0, px, py, pz,
                                          rnd_word(), rnd_word(), rnd_word(),
                                          rnd_prop(), rnd_prop()));
        end
      endcase
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_nodes.size() == 0 && !drv_busy);
    wait (expected_elems.size() == 0);
    repeat (700) @(posedge clk);
    if (expected_elems.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
